// ----- rtl/hica_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hica_pkg
// Shared types, constants and the per-color statistics function for the
// hue/intensity color adjust pipeline.
// ----------------------------------------------------------------------------
package hica_pkg;

  localparam int BYTE_W      = 8;
  localparam int SUM_W       = 10;
  localparam int REM_W       = 11;
  localparam int WEIGHT_W    = 18;
  localparam int WEIGHT_FRAC = 16;
  localparam int MODE_W      = 3;
  localparam int GRAY_RECIP  = 683;
  localparam int GRAY_SHIFT  = 11;
  localparam logic [SUM_W-1:0] FULL_SUM = 10'd765;

  localparam logic REG_MODE   = 1'b0;
  localparam logic REG_WEIGHT = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_INTENSITY  = 3'd0,
    MODE_SATURATION = 3'd1,
    MODE_BLEND      = 3'd2,
    MODE_LIGHTEN    = 3'd3,
    MODE_DARKEN     = 3'd4,
    MODE_GRAY       = 3'd5
  } mode_t;

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [BYTE_W-1:0] chroma;
    logic [BYTE_W-1:0] diff;
    logic [1:0]        base;
    logic              neg;
    logic              gray;
  } stats_t;

  typedef struct packed {
    logic              pass;
    logic [BYTE_W-1:0] r;
    logic [BYTE_W-1:0] g;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] a;
  } pix_t;

  function automatic stats_t color_stats(input logic [BYTE_W-1:0] r,
                                         input logic [BYTE_W-1:0] g,
                                         input logic [BYTE_W-1:0] b);
    stats_t            o;
    logic [BYTE_W-1:0] mx;
    logic [BYTE_W-1:0] mn;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    o.sum    = {2'b00, r} + {2'b00, g} + {2'b00, b};
    o.chroma = mx - mn;
    o.gray   = (mx == mn);
    if (r == mx) begin
      o.base = 2'd0;
      o.neg  = (g < b);
      o.diff = (g >= b) ? g - b : b - g;
    end else if (g == mx) begin
      o.base = 2'd1;
      o.neg  = (b < r);
      o.diff = (b >= r) ? b - r : r - b;
    end else begin
      o.base = 2'd2;
      o.neg  = (r < g);
      o.diff = (r >= g) ? r - g : g - r;
    end
    return o;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/hue_intensity_color_adjust_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hue_intensity_color_adjust_top
// Pipelined RGB to HSI adjust and back, one pixel a clock unless stalled.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output is not stalled; the pipeline
// depth is set by the divider pipeline, which resolves two quotient bits per
// stage (one in the last when FRAC_BITS is even) for hue and saturation of
// both the pixel and its blend target (intensity uses a reciprocal multiply).
// Every stage holds its word while the output is stalled, and empty stages
// still accept new words. Registers (mode, weight) must be written only while
// idle; the block itself does not enforce this.
module hue_intensity_color_adjust_top #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [17:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  input  wire logic [7:0]  in_alpha,
  input  wire logic [7:0]  other_red,
  input  wire logic [7:0]  other_green,
  input  wire logic [7:0]  other_blue,
  input  wire logic [7:0]  other_alpha,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [7:0]       out_alpha
);
  import hica_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int NDS = (F + 2) / 2;
  localparam int N   = NDS + 8;
  localparam int SH  = NDS + 2;
  localparam int SP  = NDS + 3;
  localparam int SA  = NDS + 4;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};
  localparam int I_SHIFT = 20;
  localparam longint I_RECIP_L = ((64'd1 << (F + I_SHIFT)) + FULL_SUM - 1) / FULL_SUM;
  localparam logic [F+10:0] I_RECIP = I_RECIP_L[F+10:0];

  typedef struct packed {
    logic [1:0] base;
    logic       neg;
    logic       gray;
  } hue_sb_t;

  typedef struct packed {
    hue_sb_t           c0;
    hue_sb_t           c1;
    pix_t              raw;
    logic [BYTE_W-1:0] ta;
    logic [F:0]        i0;
    logic [F:0]        i1;
  } side_t;

  // config
  mode_t               mode;
  logic [WEIGHT_W-1:0] weight;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_INTENSITY;
      weight <= 18'd65536;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_MODE) mode <= mode_t'(cfg_data[MODE_W-1:0]);
      else                       weight <= cfg_data;
    end
  end

  logic [WEIGHT_W+F-1:0] m_wide;
  logic [F+1:0]          m;
  logic [F:0]            w_clamp, w, wn;

  assign m_wide  = {weight, {F{1'b0}}} >> WEIGHT_FRAC;
  assign m       = m_wide[F+1:0];
  assign w_clamp = (m > {1'b0, ONE}) ? ONE : m[F:0];
  assign w       = (mode == MODE_GRAY) ? ONE - w_clamp : w_clamp;
  assign wn      = ONE - w;

  // handshake
  logic [N-1:0] v, en;

  always_comb begin
    en[N-1] = !v[N-1] || out_ready;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < N; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage 0: input word and blend target
  logic [19:0]       gray_prod;
  logic [BYTE_W-1:0] gray_b;
  logic [BYTE_W-1:0] tr_next, tg_next, tb_next, ta_next;
  pix_t              raw0;
  logic [BYTE_W-1:0] tr0, tg0, tb0, ta0;

  assign gray_prod = ({2'b00, in_red} + {2'b00, in_green} + {2'b00, in_blue})
                     * 10'(GRAY_RECIP);
  assign gray_b    = gray_prod[GRAY_SHIFT +: BYTE_W];

  always_comb begin
    ta_next = in_alpha;
    case (mode)
      MODE_BLEND: begin
        tr_next = other_red; tg_next = other_green; tb_next = other_blue;
        ta_next = other_alpha;
      end
      MODE_LIGHTEN: begin tr_next = 8'hFF; tg_next = 8'hFF; tb_next = 8'hFF; end
      MODE_GRAY:    begin tr_next = gray_b; tg_next = gray_b; tb_next = gray_b; end
      default:      begin tr_next = 8'h00; tg_next = 8'h00; tb_next = 8'h00; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      raw0.pass <= (mode != MODE_INTENSITY) && (mode != MODE_SATURATION) &&
                   (mode != MODE_BLEND) && (mode != MODE_LIGHTEN) &&
                   (mode != MODE_DARKEN) && (mode != MODE_GRAY);
      raw0.r <= in_red;
      raw0.g <= in_green;
      raw0.b <= in_blue;
      raw0.a <= in_alpha;
      tr0 <= tr_next;
      tg0 <= tg_next;
      tb0 <= tb_next;
      ta0 <= ta_next;
    end
  end

  // stage 1: channel statistics
  stats_t            st0, st1;
  pix_t              raw1;
  logic [BYTE_W-1:0] ta1;
  logic [F+20:0]     ip0, ip1;
  side_t             side1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      st0  <= color_stats(raw0.r, raw0.g, raw0.b);
      st1  <= color_stats(tr0, tg0, tb0);
      raw1 <= raw0;
      ta1  <= ta0;
    end
  end

  // intensity = sum / 765 by reciprocal multiply
  assign ip0 = st0.sum * I_RECIP;
  assign ip1 = st1.sum * I_RECIP;

  always_comb begin
    side1.c0  = '{base: st0.base, neg: st0.neg, gray: st0.gray};
    side1.c1  = '{base: st1.base, neg: st1.neg, gray: st1.gray};
    side1.raw = raw1;
    side1.ta  = ta1;
    side1.i0  = ip0[I_SHIFT +: F+1];
    side1.i1  = ip1[I_SHIFT +: F+1];
  end

  // divider stages
  logic [F:0] qs0, qh0, qs1, qh1;
  side_t      sbd [NDS];

  hica_div #(.F(F)) u_div_s0 (.clk(clk), .en(en[2 +: NDS]),
    .num({2'b00, st0.chroma}), .den(st0.sum), .quo(qs0));
  hica_div #(.F(F)) u_div_h0 (.clk(clk), .en(en[2 +: NDS]),
    .num({2'b00, st0.diff}), .den({2'b00, st0.chroma}), .quo(qh0));
  hica_div #(.F(F)) u_div_s1 (.clk(clk), .en(en[2 +: NDS]),
    .num({2'b00, st1.chroma}), .den(st1.sum), .quo(qs1));
  hica_div #(.F(F)) u_div_h1 (.clk(clk), .en(en[2 +: NDS]),
    .num({2'b00, st1.diff}), .den({2'b00, st1.chroma}), .quo(qh1));

  always_ff @(posedge clk) begin
    if (en[2]) sbd[0] <= side1;
    for (int k = 1; k < NDS; k++) begin
      if (en[2+k]) sbd[k] <= sbd[k-1];
    end
  end

  // hue assembly
  function automatic logic [F+2:0] make_hue(input hue_sb_t sb, input logic [F:0] fr);
    logic [F+2:0] basev;
    basev = {sb.base, 1'b0, {F{1'b0}}};
    if (sb.gray)                          return '0;
    else if (sb.neg && sb.base == 2'd0)   return {3'd6, {F{1'b0}}} - {2'b00, fr};
    else if (sb.neg)                      return basev - {2'b00, fr};
    else                                  return basev + {2'b00, fr};
  endfunction

  logic [F+2:0] h0h, h1h;
  logic [F:0]   s0h, i0h, s1h, i1h;
  side_t        sideh;

  always_ff @(posedge clk) begin
    if (en[SH]) begin
      h0h   <= make_hue(sbd[NDS-1].c0, qh0);
      h1h   <= make_hue(sbd[NDS-1].c1, qh1);
      s0h   <= sbd[NDS-1].c0.gray ? '0 : qs0;
      s1h   <= sbd[NDS-1].c1.gray ? '0 : qs1;
      i0h   <= sbd[NDS-1].i0;
      i1h   <= sbd[NDS-1].i1;
      sideh <= sbd[NDS-1];
    end
  end

  // products
  logic [2*F+3:0]   ha, hb;
  logic [2*F+1:0]   sa, sb, ia, ib;
  logic [F+8:0]     aa, ab;
  logic [2*F+2:0]   sc;
  logic [F+2:0]     h0p;
  logic [F:0]       s0p, i0p;
  side_t            sidep;

  always_ff @(posedge clk) begin
    if (en[SP]) begin
      ha    <= h0h * wn;
      hb    <= h1h * w;
      sa    <= s0h * wn;
      sb    <= s1h * w;
      ia    <= i0h * wn;
      ib    <= i1h * w;
      aa    <= sideh.raw.a * wn;
      ab    <= sideh.ta * w;
      sc    <= ((mode == MODE_SATURATION) ? s0h : i0h) * m;
      h0p   <= h0h;
      s0p   <= s0h;
      i0p   <= i0h;
      sidep <= sideh;
    end
  end

  // mode select
  logic [2*F+4:0] hsum;
  logic [2*F+2:0] ssum, isum;
  logic [F+9:0]   asum;
  logic [F+2:0]   scaled, h_next;
  logic [F:0]     sc_clamp, s_next, i_next;
  pix_t           pix_next;
  logic [F+2:0]   ha_r;
  logic [F:0]     sa_r, ia_r;
  pix_t           pix_a;

  assign hsum     = {1'b0, ha} + {1'b0, hb};
  assign ssum     = {1'b0, sa} + {1'b0, sb};
  assign isum     = {1'b0, ia} + {1'b0, ib};
  assign asum     = {1'b0, aa} + {1'b0, ab};
  assign scaled   = sc[F +: F+3];
  assign sc_clamp = (scaled > {2'b00, ONE}) ? ONE : scaled[F:0];

  always_comb begin
    h_next   = h0p;
    s_next   = s0p;
    i_next   = i0p;
    pix_next = sidep.raw;
    case (mode)
      MODE_INTENSITY:  i_next = sc_clamp;
      MODE_SATURATION: s_next = sc_clamp;
      MODE_BLEND, MODE_LIGHTEN, MODE_DARKEN, MODE_GRAY: begin
        h_next = hsum[F +: F+3];
        s_next = ssum[F +: F+1];
        i_next = isum[F +: F+1];
        if (sidep.ta != sidep.raw.a) pix_next.a = asum[F +: BYTE_W];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[SA]) begin
      ha_r  <= h_next;
      sa_r  <= s_next;
      ia_r  <= i_next;
      pix_a <= pix_next;
    end
  end

  hica_to_rgb #(.F(F)) u_to_rgb (
    .clk  (clk),
    .en   (en[N-3 +: 3]),
    .h    (ha_r),
    .s    (sa_r),
    .i    (ia_r),
    .side (pix_a),
    .out_r(out_red),
    .out_g(out_green),
    .out_b(out_blue),
    .out_a(out_alpha)
  );

`ifndef NO_ASSERTIONS
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    ($countones(v) == N) && !out_ready |-> !in_ready)
    else $error("input taken while pipeline full and stalled");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v[0])
    else $error("accepted word not in first stage");

  a_stall_keeps: assert property (@(posedge clk) disable iff (rst)
    v[SA] && !en[SA] |=> v[SA])
    else $error("stalled word dropped");
`endif

endmodule
`default_nettype wire

// ----- rtl/hica_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hica_div
// Pipelined restoring divider: quo = floor(num * 2^F / den) for num <= den,
// two quotient bits per register stage, one in the last stage when F is even.
// ----------------------------------------------------------------------------
module hica_div #(
  parameter int F = 16
) (
  input  wire logic                          clk,
  input  wire logic [(F+2)/2-1:0]            en,
  input  wire logic [hica_pkg::SUM_W-1:0]    num,
  input  wire logic [hica_pkg::SUM_W-1:0]    den,
  output logic      [F:0]                    quo
);
  import hica_pkg::*;

  localparam int NQ  = F + 1;
  localparam int NDS = (NQ + 1) / 2;

  logic [REM_W-1:0] rem [NDS];
  logic [SUM_W-1:0] dd  [NDS];
  logic [F:0]       q   [NDS];

  genvar s;
  generate
    for (s = 0; s < NDS; s++) begin : g_stage
      logic [REM_W-1:0] r_in;
      logic [REM_W-1:0] r_next;
      logic [F:0]       q_in;
      logic [F:0]       q_next;
      logic [SUM_W-1:0] d_cur;

      if (s == 0) begin : g_first
        assign r_in  = {1'b0, num};
        assign q_in  = '0;
        assign d_cur = den;
      end else begin : g_rest
        assign r_in  = rem[s-1];
        assign q_in  = q[s-1];
        assign d_cur = dd[s-1];
      end

      always_comb begin
        logic [REM_W-1:0] r;
        logic [F:0]       qq;
        logic             bit_q;
        r     = r_in;
        qq    = q_in;
        bit_q = 1'b0;
        for (int j = 0; j < 2; j++) begin
          if (s * 2 + j < NQ) begin
            bit_q = (r >= {1'b0, d_cur});
            if (bit_q) r = r - {1'b0, d_cur};
            qq = {qq[F-1:0], bit_q};
            r  = {r[REM_W-2:0], 1'b0};
          end
        end
        r_next = r;
        q_next = qq;
      end

      always_ff @(posedge clk) begin
        if (en[s]) begin
          rem[s] <= r_next;
          q[s]   <= q_next;
          dd[s]  <= d_cur;
        end
      end
    end
  endgenerate

  assign quo = q[NDS-1];

endmodule
`default_nettype wire

// ----- rtl/hica_to_rgb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hica_to_rgb
// Three-stage hexcone sector conversion from hue/saturation/intensity back
// to truncated bytes, with pass-through of unchanged pixels.
// ----------------------------------------------------------------------------
module hica_to_rgb #(
  parameter int F = 16
) (
  input  wire logic                         clk,
  input  wire logic [2:0]                   en,
  input  wire logic [F+2:0]                 h,
  input  wire logic [F:0]                   s,
  input  wire logic [F:0]                   i,
  input  wire hica_pkg::pix_t               side,
  output logic      [hica_pkg::BYTE_W-1:0]  out_r,
  output logic      [hica_pkg::BYTE_W-1:0]  out_g,
  output logic      [hica_pkg::BYTE_W-1:0]  out_b,
  output logic      [hica_pkg::BYTE_W-1:0]  out_a
);
  import hica_pkg::*;

  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  function automatic logic [BYTE_W-1:0] to_byte(input logic [F:0] v);
    logic [F+8:0] x;
    x = {v, 8'b0} - {8'b0, v};
    return x[F +: BYTE_W];
  endfunction

  // stage 1
  logic [2:0] sec1;
  logic [F:0] i1, p1, sf1, s1f1;
  pix_t       side1;
  logic [2*F+1:0] p_full, sf_full, s1f_full;
  logic [F:0]     f_inv;

  assign f_inv    = ONE - {1'b0, h[F-1:0]};
  assign p_full   = i * (ONE - s);
  assign sf_full  = s * {1'b0, h[F-1:0]};
  assign s1f_full = s * f_inv;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sec1  <= h[F+2:F];
      i1    <= i;
      p1    <= p_full[F +: F+1];
      sf1   <= sf_full[F +: F+1];
      s1f1  <= s1f_full[F +: F+1];
      side1 <= side;
    end
  end

  // stage 2
  logic [2:0] sec2;
  logic [F:0] i2, p2, q2, t2;
  pix_t       side2;
  logic [2*F+1:0] q_full, t_full;

  assign q_full = i1 * (ONE - sf1);
  assign t_full = i1 * (ONE - s1f1);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sec2  <= sec1;
      i2    <= i1;
      p2    <= p1;
      q2    <= q_full[F +: F+1];
      t2    <= t_full[F +: F+1];
      side2 <= side1;
    end
  end

  // stage 3
  logic [F:0] rv, gv, bv;

  always_comb begin
    case (sec2)
      3'd1: begin rv = q2; gv = i2; bv = p2; end
      3'd2: begin rv = p2; gv = i2; bv = t2; end
      3'd3: begin rv = p2; gv = q2; bv = i2; end
      3'd4: begin rv = t2; gv = p2; bv = i2; end
      3'd5: begin rv = i2; gv = p2; bv = q2; end
      default: begin rv = i2; gv = t2; bv = p2; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      out_r <= side2.pass ? side2.r : to_byte(rv);
      out_g <= side2.pass ? side2.g : to_byte(gv);
      out_b <= side2.pass ? side2.b : to_byte(bv);
      out_a <= side2.a;
    end
  end

endmodule
`default_nettype wire
